// ===== hw/rtl/ellipsoid_support_point_macros.svh =====
// assertion macros for the ellipsoid support point block
`ifndef ELLIPSOID_SUPPORT_POINT_MACROS_SVH
`define ELLIPSOID_SUPPORT_POINT_MACROS_SVH
`ifndef SYNTH
`define ESP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("esp assertion failed");
`define ESP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("esp assertion failed");
`else
`define ESP_ASSERT(lbl, prop)
`define ESP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/esp_pkg.sv =====
package esp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int AXIS_W    = 31;
	localparam int DIR_W     = 32;
	localparam int PROD_W    = 63;
	localparam int LIMB_W    = 32;
	localparam int MUL_LIMBS = 3;
	localparam int MUL_W     = LIMB_W * MUL_LIMBS;
	localparam int MULP_W    = 2 * MUL_W;
	localparam int Q_W       = 128;
	localparam int ROOT_BITS = 31;
	localparam int WORK_W    = 192;
	localparam int ADDR_W    = 4;
	localparam int BIT_W     = 5;

	localparam logic [AXIS_W-1:0] SEMI_RESET = AXIS_W'(1 << FRAC_BITS);

	// register indexes
	localparam logic [1:0] REG_SEMI_X = 2'd0;
	localparam logic [1:0] REG_SEMI_Y = 2'd1;
	localparam logic [1:0] REG_SEMI_Z = 2'd2;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} req_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] point_x;
		logic signed [DIR_W-1:0] point_y;
		logic signed [DIR_W-1:0] point_z;
		logic                    degenerate;
	} rsp_t;

	// control that travels with an item down the pipe
	typedef struct packed {
		logic       valid;
		logic       deg;
		logic [2:0] neg;
	} ctl_t;

endpackage

// ===== hw/rtl/ellipsoid_support_point.sv =====
// Support point of an axis-aligned ellipsoid, semi-axes held in three registers.
// Request channel req (req_valid/req_stall) carries a signed Q16.16 direction;
// response channel rsp (rsp_valid/rsp_stall) returns the support point
// p_i = s_i^2 v_i / |D v|, each coordinate truncated toward zero, plus the
// degenerate flag, set with the point (semi_axis_x, 0, 0) when the direction or
// the scaled direction is zero.
// From acceptance to rsp_valid an item passes the register for |v| and s*|v|,
// the two chained multipliers (each registers 32x32 limb products, then their
// sum; the sum of squares runs beside the second one), 31 root stages that each
// settle one result bit with a wide subtract and compare, and the output
// register. One item per cycle is taken unless a stall on rsp with rsp_valid
// high freezes the whole pipe; req_stall follows it in the same cycle.
// Reset clears all valid bits and sets each semi-axis to 1.0.
// Semi-axes are written over the APB port at byte addresses 0, 4 and 8. The user
// must write them only while no item is in flight; the block does not enforce it.
`include "ellipsoid_support_point_macros.svh"
module ellipsoid_support_point (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [esp_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  esp_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output esp_pkg::rsp_t                 rsp
);

	logic [esp_pkg::AXIS_W-1:0] semi_axis_x_q;
	logic [esp_pkg::AXIS_W-1:0] semi_axis_y_q;
	logic [esp_pkg::AXIS_W-1:0] semi_axis_z_q;
	logic [esp_pkg::AXIS_W-1:0] semi [3];
	logic [esp_pkg::DIR_W-1:0]  dir [3];
	logic [esp_pkg::DIR_W-1:0]  mag [3];
	logic                       adv;

	logic [esp_pkg::PROD_W-1:0]  a_s1 [3];
	esp_pkg::ctl_t               ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [esp_pkg::MULP_W-1:0]  asq [3];
	logic [esp_pkg::MULP_W-1:0]  nv [3];
	logic [esp_pkg::MULP_W-1:0]  nsq [3];
	logic [esp_pkg::Q_W-1:0]     q_s4, q_s5;

	esp_pkg::ctl_t                 ctl_r [esp_pkg::ROOT_BITS+1];
	logic [esp_pkg::Q_W-1:0]       q_r   [esp_pkg::ROOT_BITS+1];
	logic [esp_pkg::WORK_W-1:0]    e_r   [esp_pkg::ROOT_BITS+1][3];
	logic [esp_pkg::WORK_W-1:0]    rq_r  [esp_pkg::ROOT_BITS+1][3];
	logic [esp_pkg::ROOT_BITS-1:0] r_r   [esp_pkg::ROOT_BITS+1][3];

	logic                       rsp_valid_q;
	esp_pkg::rsp_t              rsp_q;
	logic [esp_pkg::DIR_W-1:0]  res [3];
	logic [esp_pkg::DIR_W-1:0]  abs_x;
	logic [esp_pkg::DIR_W-1:0]  abs_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			semi_axis_x_q <= esp_pkg::SEMI_RESET;
			semi_axis_y_q <= esp_pkg::SEMI_RESET;
			semi_axis_z_q <= esp_pkg::SEMI_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				esp_pkg::REG_SEMI_X: semi_axis_x_q <= pwdata[esp_pkg::AXIS_W-1:0];
				esp_pkg::REG_SEMI_Y: semi_axis_y_q <= pwdata[esp_pkg::AXIS_W-1:0];
				esp_pkg::REG_SEMI_Z: semi_axis_z_q <= pwdata[esp_pkg::AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			esp_pkg::REG_SEMI_X: prdata = {1'b0, semi_axis_x_q};
			esp_pkg::REG_SEMI_Y: prdata = {1'b0, semi_axis_y_q};
			esp_pkg::REG_SEMI_Z: prdata = {1'b0, semi_axis_z_q};
			default:             prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	assign semi[0] = semi_axis_x_q;
	assign semi[1] = semi_axis_y_q;
	assign semi[2] = semi_axis_z_q;

	// the whole pipe moves unless a finished item is held
	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;

	// stage 1: magnitudes and scaled direction
	assign dir[0] = req.dir_x;
	assign dir[1] = req.dir_y;
	assign dir[2] = req.dir_z;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = dir[i][esp_pkg::DIR_W-1] ? (~dir[i] + 1'b1) : dir[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= esp_pkg::PROD_W'(semi[i]) * esp_pkg::PROD_W'(mag[i]);
			end
		end
	end

	// control pipe ahead of the root stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= req_valid;
			ctl_s1.deg   <= (mag[0] | mag[1] | mag[2]) == '0;
			ctl_s1.neg   <= {dir[2][esp_pkg::DIR_W-1], dir[1][esp_pkg::DIR_W-1],
				dir[0][esp_pkg::DIR_W-1]};
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			ctl_s4       <= ctl_s3;
			ctl_s5.valid <= ctl_s4.valid;
			ctl_s5.neg   <= ctl_s4.neg;
			ctl_s5.deg   <= ctl_s4.deg || (q_s4 == '0);
		end
	end

	// squares and numerators, per lane
	for (genvar i = 0; i < 3; i++) begin : g_lane
		esp_mul u_asq (
			.clk (clk),
			.en  (adv),
			.a   (esp_pkg::MUL_W'(a_s1[i])),
			.b   (esp_pkg::MUL_W'(a_s1[i])),
			.p   (asq[i])
		);
		esp_mul u_num (
			.clk (clk),
			.en  (adv),
			.a   (esp_pkg::MUL_W'(semi[i])),
			.b   (esp_pkg::MUL_W'(a_s1[i])),
			.p   (nv[i])
		);
		esp_mul u_nsq (
			.clk (clk),
			.en  (adv),
			.a   (nv[i][esp_pkg::MUL_W-1:0]),
			.b   (nv[i][esp_pkg::MUL_W-1:0]),
			.p   (nsq[i])
		);
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4 <= esp_pkg::Q_W'(asq[0][esp_pkg::Q_W-1:0])
				+ esp_pkg::Q_W'(asq[1][esp_pkg::Q_W-1:0])
				+ esp_pkg::Q_W'(asq[2][esp_pkg::Q_W-1:0]);
			q_s5 <= q_s4;
		end
	end

	// root stage inputs
	assign ctl_r[0] = ctl_s5;
	assign q_r[0]   = q_s5;
	for (genvar i = 0; i < 3; i++) begin : g_init
		assign e_r[0][i]  = nsq[i][esp_pkg::WORK_W-1:0];
		assign rq_r[0][i] = '0;
		assign r_r[0][i]  = '0;
	end

	// one result bit per stage, most significant first
	for (genvar k = 0; k < esp_pkg::ROOT_BITS; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_r[k+1] <= '0;
			end else if (adv) begin
				ctl_r[k+1] <= ctl_r[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_r[k+1] <= q_r[k];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_ln
			esp_root_step u_step (
				.clk     (clk),
				.en      (adv),
				.bit_idx (esp_pkg::BIT_W'(esp_pkg::ROOT_BITS - 1 - k)),
				.q       (q_r[k]),
				.e_in    (e_r[k][i]),
				.rq_in   (rq_r[k][i]),
				.r_in    (r_r[k][i]),
				.e_out   (e_r[k+1][i]),
				.rq_out  (rq_r[k+1][i]),
				.r_out   (r_r[k+1][i])
			);
		end
	end

	// sign selection
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = ctl_r[esp_pkg::ROOT_BITS].neg[i]
				? (~esp_pkg::DIR_W'(r_r[esp_pkg::ROOT_BITS][i]) + 1'b1)
				: esp_pkg::DIR_W'(r_r[esp_pkg::ROOT_BITS][i]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ctl_r[esp_pkg::ROOT_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_r[esp_pkg::ROOT_BITS].deg) begin
				rsp_q.point_x <= {1'b0, semi_axis_x_q};
				rsp_q.point_y <= '0;
				rsp_q.point_z <= '0;
			end else begin
				rsp_q.point_x <= res[0];
				rsp_q.point_y <= res[1];
				rsp_q.point_z <= res[2];
			end
			rsp_q.degenerate <= ctl_r[esp_pkg::ROOT_BITS].deg;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// magnitudes of the returned coordinates
	assign abs_x = rsp.point_x[31] ? (~rsp.point_x + 1'b1) : rsp.point_x;
	assign abs_z = rsp.point_z[31] ? (~rsp.point_z + 1'b1) : rsp.point_z;

	// checks
	`ESP_ASSERT(a_deg_axis, rsp_valid && rsp.degenerate |-> rsp.point_y == '0 && rsp.point_z == '0)
	`ESP_ASSERT(a_x_bound, rsp_valid && !rsp.degenerate |-> abs_x <= {1'b0, semi_axis_x_q})
	`ESP_ASSERT(a_z_bound, rsp_valid && !rsp.degenerate |-> abs_z <= {1'b0, semi_axis_z_q})
	`ESP_ASSERT(a_zero_dir, req_valid && !req_stall && req == '0 |=> ctl_s1.deg)

endmodule

// ===== hw/rtl/esp_mul.sv =====
module esp_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [esp_pkg::MUL_W-1:0]     a,
	input  logic [esp_pkg::MUL_W-1:0]     b,
	output logic [esp_pkg::MULP_W-1:0]    p
);

	logic [2*esp_pkg::LIMB_W-1:0] pp_s1 [esp_pkg::MUL_LIMBS][esp_pkg::MUL_LIMBS];
	logic [esp_pkg::MULP_W-1:0]   sum;

	// limb partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < esp_pkg::MUL_LIMBS; i++) begin
				for (int j = 0; j < esp_pkg::MUL_LIMBS; j++) begin
					pp_s1[i][j] <= a[i*esp_pkg::LIMB_W +: esp_pkg::LIMB_W]
						* b[j*esp_pkg::LIMB_W +: esp_pkg::LIMB_W];
				end
			end
		end
	end

	// shifted sum of partial products
	always_comb begin
		sum = '0;
		for (int i = 0; i < esp_pkg::MUL_LIMBS; i++) begin
			for (int j = 0; j < esp_pkg::MUL_LIMBS; j++) begin
				sum = sum + (esp_pkg::MULP_W'(pp_s1[i][j]) << (esp_pkg::LIMB_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sum;
		end
	end

endmodule

// ===== hw/rtl/esp_root_step.sv =====
module esp_root_step (
	input  logic                             clk,
	input  logic                             en,
	input  logic [esp_pkg::BIT_W-1:0]        bit_idx,
	input  logic [esp_pkg::Q_W-1:0]          q,
	input  logic [esp_pkg::WORK_W-1:0]       e_in,
	input  logic [esp_pkg::WORK_W-1:0]       rq_in,
	input  logic [esp_pkg::ROOT_BITS-1:0]    r_in,
	output logic [esp_pkg::WORK_W-1:0]       e_out,
	output logic [esp_pkg::WORK_W-1:0]       rq_out,
	output logic [esp_pkg::ROOT_BITS-1:0]    r_out
);

	logic [esp_pkg::WORK_W-1:0] qsh;
	logic [esp_pkg::WORK_W-1:0] t;
	logic                       take;

	// trial bit: (r + 2^b)^2 q - r^2 q = (2 r q + q 2^b) 2^b against the remainder
	always_comb begin
		qsh  = esp_pkg::WORK_W'(q) << bit_idx;
		t    = ((rq_in << 1) + qsh) << bit_idx;
		take = (t <= e_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_out  <= take ? (e_in - t) : e_in;
			rq_out <= take ? (rq_in + qsh) : rq_in;
			r_out  <= take ? (r_in | (esp_pkg::ROOT_BITS'(1) << bit_idx)) : r_in;
		end
	end

endmodule

// ===== tb/sv/tb_ellipsoid_support_point.sv =====
`timescale 1ns / 100ps
module tb_ellipsoid_support_point;

	localparam int LATENCY    = 37;
	localparam int SETTLE     = LATENCY + 10;
	localparam int WATCH_MAX  = 4000;
	localparam int RAND_ITEMS = 1900;
	localparam int QUIET_FROM = 1700;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 250;
	localparam logic [1:0] REG_BEYOND = 2'd3;

	typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_KNOWN, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic [1:0]     reg_idx;
		logic [31:0]    wdata;
		esp_pkg::req_t  dir;
		esp_pkg::rsp_t  want;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [esp_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic req_valid, req_stall, rsp_valid, rsp_stall;
	esp_pkg::req_t req;
	esp_pkg::rsp_t rsp;

	// side band: typed expectation for the item now offered
	logic has_want;
	esp_pkg::rsp_t want_now;

	logic [esp_pkg::AXIS_W-1:0] semi [3];
	esp_pkg::rsp_t point_q [$];
	int err_cnt;
	int sent_cnt;
	int idle_cnt;
	bit quiet;

	ellipsoid_support_point u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact support point: trunc(s_i^2 v_i / sqrt(sum (s_j v_j)^2))
	function automatic esp_pkg::rsp_t support_of(esp_pkg::req_t d);
		logic [31:0]  mag [3];
		logic         neg [3];
		logic [62:0]  prod [3];
		logic [31:0]  raw [3];
		logic [127:0] qsum;
		logic [255:0] n2, lhs;
		logic [30:0]  r, c;
		esp_pkg::rsp_t p;
		raw[0] = d.dir_x;
		raw[1] = d.dir_y;
		raw[2] = d.dir_z;
		qsum = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = raw[i][31];
			mag[i] = neg[i] ? (~raw[i] + 32'd1) : raw[i];
			prod[i] = 63'(semi[i]) * 63'(mag[i]);
			qsum += 128'(prod[i]) * 128'(prod[i]);
		end
		if ((mag[0] | mag[1] | mag[2]) == 0 || qsum == 0) begin
			p.point_x = {1'b0, semi[0]};
			p.point_y = '0;
			p.point_z = '0;
			p.degenerate = 1'b1;
			return p;
		end
		for (int i = 0; i < 3; i++) begin
			n2 = 256'(semi[i]) * 256'(prod[i]);
			n2 = n2 * n2;
			r = '0;
			for (int b = 30; b >= 0; b--) begin
				c = r | (31'd1 << b);
				lhs = 256'(c) * 256'(c) * 256'(qsum);
				if (lhs <= n2)
					r = c;
			end
			raw[i] = neg[i] ? (~{1'b0, r} + 32'd1) : {1'b0, r};
		end
		p.point_x = raw[0];
		p.point_y = raw[1];
		p.point_z = raw[2];
		p.degenerate = 1'b0;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
		err_cnt++;
	endtask

	// wait until the pipe has drained, then write one semi-axis
	task automatic write_semi(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		wait (point_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx != REG_BEYOND)
			semi[idx] = data[esp_pkg::AXIS_W-1:0];
	endtask

	// offer one item and hold it until accepted, then maybe leave a gap
	task automatic send_dir(esp_pkg::req_t d, bit known, esp_pkg::rsp_t want);
		req_valid <= 1'b1;
		req <= d;
		has_want <= known;
		want_now <= want;
		do @(posedge clk); while (req_stall);
		sent_cnt++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
			4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20))
					: -32'($urandom_range(0, 1 << 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_semi();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'h7fff_ffff;
			2: return 32'h0001_0000;
			3: return 32'($urandom_range(1, 1 << 20));
			default: return $urandom;
		endcase
	endfunction

	// request side: directed table then random items
	initial begin
		row_t rows [$];
		esp_pkg::req_t d;
		esp_pkg::rsp_t none;
		none = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		has_want = 1'b0;
		want_now = '0;
		err_cnt = 0;
		sent_cnt = 0;
		quiet = 1'b0;
		for (int i = 0; i < 3; i++)
			semi[i] = esp_pkg::SEMI_RESET;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset all semi-axes are 1.0
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{0, 0, 0}, '{32'h1_0000, 0, 0, 1'b1}});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{32'h1_0000, 0, 0}, '{32'h1_0000, 0, 0, 1'b0}});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{-32'sh1_0000, 0, 0},
			'{-32'sh1_0000, 0, 0, 1'b0}});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{0, 32'h7fff_ffff, 0}, '{0, 32'h1_0000, 0, 1'b0}});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{0, 0, 32'h8000_0000},
			'{0, 0, -32'sh1_0000, 1'b0}});
		rows.push_back('{ROW_ITEM, 0, 0, '{1, 1, 1}, none});
		rows.push_back('{ROW_ITEM, 0, 0, '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}, none});
		// a zero semi-axis on one component only
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_Y, 32'd0, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM, 0, 0, '{1, 1, 1}, none});
		// upper register bit is dropped, and index three is ignored
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_Z, 32'h8003_0000, '{0, 0, 0}, none});
		rows.push_back('{ROW_CFG, REG_BEYOND, 32'h1234_5678, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM, 0, 0, '{-32'sd7, 32'sd9, 32'h7fff_ffff}, none});
		// zero scaled direction: first only the zero x axis is hit, then all semi-axes are zero
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_X, 32'd0, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{32'sd5, 0, 0}, '{0, 0, 0, 1'b1}});
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_Z, 32'd0, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{32'h7fff_ffff, 32'h8000_0000, 32'sd3},
			'{0, 0, 0, 1'b1}});
		// largest x semi-axis along x returns the axis itself
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_X, 32'h7fff_ffff, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{1, 0, 0}, '{32'h7fff_ffff, 0, 0, 1'b0}});
		rows.push_back('{ROW_ITEM_KNOWN, 0, 0, '{0, 0, 0}, '{32'h7fff_ffff, 0, 0, 1'b1}});
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_Y, 32'h7fff_ffff, '{0, 0, 0}, none});
		rows.push_back('{ROW_CFG, esp_pkg::REG_SEMI_Z, 32'h7fff_ffff, '{0, 0, 0}, none});
		rows.push_back('{ROW_ITEM, 0, 0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, none});
		rows.push_back('{ROW_ITEM, 0, 0, '{32'h7fff_ffff, 32'hffff_ffff, 32'sd1}, none});

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				req_valid <= 1'b0;
				write_semi(rows[i].reg_idx, rows[i].wdata);
			end else begin
				send_dir(rows[i].dir, rows[i].kind == ROW_ITEM_KNOWN, rows[i].want);
			end
		end

		// random items, new semi-axes every few hundred
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 300 == 0) begin
				req_valid <= 1'b0;
				for (int k = 0; k < 3; k++)
					write_semi(2'(k), pick_semi());
			end
			if (n == QUIET_FROM)
				quiet = 1'b1;
			d.dir_x = pick_comp();
			d.dir_y = pick_comp();
			d.dir_z = pick_comp();
			send_dir(d, 1'b0, none);
		end
		req_valid <= 1'b0;
		@(posedge clk);
		wait (point_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// response side: random stall bursts and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		rsp_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && sent_cnt >= HOLD_AT) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// predict on item acceptance, compare on result acceptance
	always @(posedge clk) begin
		esp_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				point_q.push_back(has_want ? want_now : support_of(req));
			if (rsp_valid && !rsp_stall) begin
				if (point_q.size() == 0) begin
					$display("unexpected result %h at %0t", rsp, $time);
					err_cnt++;
				end else begin
					want = point_q.pop_front();
					if (rsp.point_x !== want.point_x)
						report_mismatch("point_x", want.point_x, rsp.point_x);
					if (rsp.point_y !== want.point_y)
						report_mismatch("point_y", want.point_y, rsp.point_y);
					if (rsp.point_z !== want.point_z)
						report_mismatch("point_z", want.point_z, rsp.point_z);
					if (rsp.degenerate !== want.degenerate)
						report_mismatch("degenerate", 32'(want.degenerate),
							32'(rsp.degenerate));
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCH_MAX) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
